>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the sorted deque.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define BSD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Same-cycle implication.
`define BSD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BSD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/bsd_pkg.sv
// Types and operation codes for the bounded sorted deque.
// No dependencies; used by bsd_cell and bounded_sorted_deque.
`timescale 1ns / 1ps

package bsd_pkg;

	typedef enum logic [2:0] {
		OP_INS_FRONT  = 3'd0,
		OP_INS_BACK   = 3'd1,
		OP_REM_FRONT  = 3'd2,
		OP_REM_BACK   = 3'd3,
		OP_INS_SORTED = 3'd4
	} op_t;

	localparam int OP_W = 3;

	// Lowest field in the lowest bits, same layout as the stream data.
	typedef struct packed {
		logic [31:0]        grade_three;
		logic [31:0]        grade_two;
		logic [31:0]        grade_one;
		logic [47:0]        name_d;
		logic [63:0]        name_c;
		logic [63:0]        name_b;
		logic [63:0]        name_a;
		logic signed [31:0] key;
	} record_t;

	localparam int REC_W = $bits(record_t);

	// Broadcast to every cell.
	typedef struct packed {
		logic upd;
		op_t  op;
	} cell_cmd_t;

endpackage

>>> rtl/bsd_cell.sv
// One slot of the deque: a record, its valid bit and the shift/insert steering.
// Depends on bsd_pkg.
`timescale 1ns / 1ps

module bsd_cell import bsd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cmd_t cmd,
	input  record_t   new_rec,
	input  record_t   left_rec,
	input  logic      left_valid,
	input  logic      left_stay,
	input  record_t   right_rec,
	input  logic      right_valid,
	output record_t   rec,
	output logic      valid,
	output logic      stay,
	output logic      is_last
);

	record_t rec_q;
	logic    valid_q;
	logic    key_lt;

	assign key_lt  = $signed(rec_q.key) < $signed(new_rec.key);
	// a cell keeps its record only if every cell in front of it does too
	assign stay    = valid_q & left_stay & ((cmd.op == OP_INS_BACK) |
		((cmd.op == OP_INS_SORTED) & key_lt));
	assign is_last = valid_q & ~right_valid;
	assign rec     = rec_q;
	assign valid   = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.upd) begin
			case (cmd.op)
				OP_INS_FRONT, OP_INS_BACK, OP_INS_SORTED: begin
					if (!stay) begin
						valid_q <= left_stay ? 1'b1 : left_valid;
					end
				end
				OP_REM_FRONT: valid_q <= right_valid;
				OP_REM_BACK:  valid_q <= valid_q & right_valid;
				default:      valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			case (cmd.op)
				OP_INS_FRONT, OP_INS_BACK, OP_INS_SORTED: begin
					if (!stay) begin
						rec_q <= left_stay ? new_rec : left_rec;
					end
				end
				OP_REM_FRONT: rec_q <= right_rec;
				default:      rec_q <= rec_q;
			endcase
		end
	end

endmodule

>>> rtl/bounded_sorted_deque.sv
// Bounded deque of keyed records with front/back/sorted insert, built as a cell chain.
// Depends on bsd_pkg, bsd_cell and assert_macros.svh.
//
//  channel   dir   handshake           payload
//  s_*       in    s_tvalid/s_tready   s_tuser: operation; s_tdata: record
//  m_*       out   m_tvalid/m_tready   m_tuser: success; m_tdata: total + removed record
//
// One item per cycle while results are taken: every cell decides its next content
// from its neighbors in the accept cycle, and the result lands in a single output
// register. m_tvalid rises in the cycle after accept.
// s_tready is low only while the output register holds an untaken result.
// Reset empties the list at once (valid bits); record storage is not cleared.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bounded_sorted_deque import bsd_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int NAME_BYTES = 30,
	localparam int CNT_W     = $clog2(CAPACITY + 1),
	localparam int OUT_W     = ((CNT_W + REC_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// operation
	input  logic [OP_W-1:0]  s_tuser,
	// record_key, name_word_a..d, grade_one, grade_two, grade_three
	input  logic [REC_W-1:0] s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// success
	output logic             m_tuser,
	// entry_total, out_key, out_name_a..d, out_grade_one..three, zero pad
	output logic [OUT_W-1:0] m_tdata
);

	localparam int NB_A = (NAME_BYTES >= 8) ? 8 : NAME_BYTES;
	localparam int NB_B = (NAME_BYTES >= 16) ? 8 : ((NAME_BYTES > 8) ? NAME_BYTES - 8 : 0);
	localparam int NB_C = (NAME_BYTES >= 24) ? 8 : ((NAME_BYTES > 16) ? NAME_BYTES - 16 : 0);
	localparam int NB_D = (NAME_BYTES >= 30) ? 6 : ((NAME_BYTES > 24) ? NAME_BYTES - 24 : 0);
	localparam logic [63:0] MASK_A = (NB_A == 8) ? '1 : ((64'd1 << (8 * NB_A)) - 64'd1);
	localparam logic [63:0] MASK_B = (NB_B == 8) ? '1 : ((64'd1 << (8 * NB_B)) - 64'd1);
	localparam logic [63:0] MASK_C = (NB_C == 8) ? '1 : ((64'd1 << (8 * NB_C)) - 64'd1);
	localparam logic [63:0] MASK_D = (64'd1 << (8 * NB_D)) - 64'd1;

	record_t          new_rec;
	record_t          raw_rec;
	op_t              op;
	cell_cmd_t        cmd;
	logic             accept;
	logic             full;
	logic             empty;
	logic             ok;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	record_t          out_rec;
	record_t          back_rec;

	record_t          rec_w   [CAPACITY];
	logic [CAPACITY-1:0] valid_w;
	logic [CAPACITY-1:0] stay_w;
	logic [CAPACITY-1:0] last_w;

	logic             m_tvalid_q;
	logic             m_tuser_q;
	logic [OUT_W-1:0] m_tdata_q;

	assign raw_rec = record_t'(s_tdata);
	always_comb begin
		new_rec        = raw_rec;
		new_rec.name_a = raw_rec.name_a & MASK_A;
		new_rec.name_b = raw_rec.name_b & MASK_B;
		new_rec.name_c = raw_rec.name_c & MASK_C;
		new_rec.name_d = raw_rec.name_d & MASK_D[47:0];
	end

	assign op       = op_t'(s_tuser);
	assign s_tready = ~m_tvalid_q | m_tready;
	assign accept   = s_tvalid & s_tready;
	assign full     = valid_w[CAPACITY-1];
	assign empty    = ~valid_w[0];

	always_comb begin
		ok        = 1'b0;
		count_nxt = count_q;
		unique case (op)
			OP_INS_FRONT, OP_INS_BACK, OP_INS_SORTED: begin
				ok        = ~full;
				count_nxt = full ? count_q : count_q + CNT_W'(1);
			end
			OP_REM_FRONT, OP_REM_BACK: begin
				ok        = ~empty;
				count_nxt = empty ? count_q : count_q - CNT_W'(1);
			end
			default: ok = 1'b0;
		endcase
	end

	assign cmd.upd = accept & ok;
	assign cmd.op  = op;

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			record_t left_rec;
			logic    left_valid;
			logic    left_stay;
			record_t right_rec;
			logic    right_valid;

			if (i == 0) begin : g_head
				assign left_rec   = new_rec;
				assign left_valid = 1'b1;
				assign left_stay  = 1'b1;
			end else begin : g_body
				assign left_rec   = rec_w[i-1];
				assign left_valid = valid_w[i-1];
				assign left_stay  = stay_w[i-1];
			end

			if (i == CAPACITY - 1) begin : g_tail
				assign right_rec   = rec_w[i];
				assign right_valid = 1'b0;
			end else begin : g_inner
				assign right_rec   = rec_w[i+1];
				assign right_valid = valid_w[i+1];
			end

			bsd_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.cmd         (cmd),
				.new_rec     (new_rec),
				.left_rec    (left_rec),
				.left_valid  (left_valid),
				.left_stay   (left_stay),
				.right_rec   (right_rec),
				.right_valid (right_valid),
				.rec         (rec_w[i]),
				.valid       (valid_w[i]),
				.stay        (stay_w[i]),
				.is_last     (last_w[i])
			);
		end
	endgenerate

	always_comb begin
		back_rec = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			back_rec = back_rec | (rec_w[k] & {REC_W{last_w[k]}});
		end
	end

	always_comb begin
		out_rec = '0;
		if (ok) begin
			case (op)
				OP_REM_FRONT: out_rec = rec_w[0];
				OP_REM_BACK:  out_rec = back_rec;
				default:      out_rec = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q    <= count_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tuser_q <= ok;
			m_tdata_q <= OUT_W'({out_rec, count_nxt});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

	`BSD_ASSERT(a_count_matches, $countones(valid_w) == count_q, "count differs from valid cells")
	`BSD_ASSERT(a_valid_prefix, ((valid_w >> 1) & ~valid_w) == '0, "hole in occupied cells")
	`BSD_ASSERT_NXT(a_result_follows, accept, m_tvalid, "accepted item gave no result")
	`BSD_ASSERT_IMP(a_fail_zero, m_tvalid && !m_tuser, m_tdata[OUT_W-1:CNT_W] == '0, "refused op carries a record")

endmodule

>>> tb/sv/bounded_sorted_deque_tb.sv
// Self-checking testbench for bounded_sorted_deque: directed and random operations
// against a queue-based shadow of the list, with random stalls on both streams.
// Depends on bsd_pkg and the bounded_sorted_deque RTL.
`timescale 1ns / 1ps

module bounded_sorted_deque_tb import bsd_pkg::*; ;

	localparam int DEPTH = 16;
	localparam int CNT_W = 5;
	localparam int OUT_W = ((CNT_W + REC_W + 7) / 8) * 8;
	localparam int RANDOM_OPS = 1225;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_AT = 900;
	localparam int HOLD_CYCLES = 300;

	localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

	localparam int FILL_ZERO = 0;
	localparam int FILL_ONES = 1;
	localparam int FILL_RAND = 2;

	localparam int MODE_FILL  = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIXED = 2;

	typedef struct packed {
		logic [OP_W-1:0] op;
		record_t         rec;
	} deque_op_t;

	typedef struct packed {
		logic             ok;
		logic [CNT_W-1:0] total;
		record_t          rec;
	} outcome_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [OP_W-1:0]  s_tuser = '0;
	logic [REC_W-1:0] s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic             m_tuser;
	logic [OUT_W-1:0] m_tdata;

	deque_op_t op_pending_q[$];
	outcome_t  outcome_q[$];
	record_t   shadow_list[$];
	deque_op_t offered;
	outcome_t  want;
	record_t   got_rec;

	int err_count = 0;
	int accepted = 0;
	int results = 0;
	int cycles = 0;
	int hold_left = 0;
	bit held = 1'b0;

	bounded_sorted_deque dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tuser(m_tuser),
		.m_tdata(m_tdata)
	);

	always #2 clk = ~clk;

	task automatic log_mismatch(input string what, input logic [63:0] got_v,
			input logic [63:0] want_v);
		$display("mismatch %s: got %h, want %h", what, got_v, want_v);
		err_count++;
	endtask

	// Applies one op to the shadow list and returns the result it should produce.
	function automatic outcome_t apply_op(input deque_op_t it);
		outcome_t res;
		int pos;
		res = '0;
		pos = 0;
		case (it.op)
			OP_INS_FRONT: if (shadow_list.size() < DEPTH) begin
				shadow_list.push_front(it.rec);
				res.ok = 1'b1;
			end
			OP_INS_BACK: if (shadow_list.size() < DEPTH) begin
				shadow_list.push_back(it.rec);
				res.ok = 1'b1;
			end
			OP_INS_SORTED: if (shadow_list.size() < DEPTH) begin
				while (pos < shadow_list.size() &&
						$signed(shadow_list[pos].key) < $signed(it.rec.key))
					pos++;
				shadow_list.insert(pos, it.rec);
				res.ok = 1'b1;
			end
			OP_REM_FRONT: if (shadow_list.size() > 0) begin
				res.rec = shadow_list.pop_front();
				res.ok = 1'b1;
			end
			OP_REM_BACK: if (shadow_list.size() > 0) begin
				res.rec = shadow_list.pop_back();
				res.ok = 1'b1;
			end
			default: ;
		endcase
		res.total = CNT_W'(shadow_list.size());
		return res;
	endfunction

	function automatic logic [31:0] rand_key();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3: return 32'hffff_ffff;
			4, 5, 6: return 32'($urandom_range(0, 8)) - 32'd4;
			default: return $urandom;
		endcase
	endfunction

	function automatic record_t make_rec(input logic [31:0] key, input int fill);
		record_t r;
		logic [63:0] w;
		if (fill == FILL_ZERO) begin
			r = '0;
		end else if (fill == FILL_ONES) begin
			r = '1;
		end else begin
			r.name_a = {$urandom, $urandom};
			r.name_b = {$urandom, $urandom};
			r.name_c = {$urandom, $urandom};
			w = {$urandom, $urandom};
			r.name_d = w[47:0];
			r.grade_one = $urandom;
			r.grade_two = $urandom;
			r.grade_three = $urandom;
		end
		r.key = key;
		return r;
	endfunction

	function automatic deque_op_t rand_op(input int mode);
		deque_op_t it;
		int r;
		int fill;
		int ins_share;
		r = $urandom_range(0, 99);
		ins_share = (mode == MODE_FILL) ? 85 : (mode == MODE_DRAIN) ? 20 : 50;
		if (r < 3) begin
			it.op = OP_W'($urandom_range(OP_RSVD5, OP_RSVD7));
		end else if ($urandom_range(0, 99) < ins_share) begin
			case ($urandom_range(0, 2))
				0: it.op = OP_INS_FRONT;
				1: it.op = OP_INS_BACK;
				default: it.op = OP_INS_SORTED;
			endcase
		end else begin
			it.op = $urandom_range(0, 1) ? OP_REM_FRONT : OP_REM_BACK;
		end
		r = $urandom_range(0, 15);
		fill = (r == 0) ? FILL_ZERO : (r == 1) ? FILL_ONES : FILL_RAND;
		it.rec = make_rec(rand_key(), fill);
		return it;
	endfunction

	task automatic queue_op(input logic [OP_W-1:0] op, input logic [31:0] key,
			input int fill);
		deque_op_t it;
		it.op = op;
		it.rec = make_rec(key, fill);
		op_pending_q.push_back(it);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (op_pending_q.size() != 0 || s_tvalid || outcome_q.size() != 0)
			@(negedge clk);
	endtask

	// Sender
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				outcome_q.push_back(apply_op(offered));
				accepted <= accepted + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (op_pending_q.size() != 0 &&
						((accepted >= 400 && accepted < 600) ||
						$urandom_range(0, 99) >= 36)) begin
					offered = op_pending_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= offered.op;
					s_tdata <= offered.rec;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver, with one long hold-off that backs up the input
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (!held && results >= HOLD_AT) begin
			held <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= (results >= 400 && results < 600) || $urandom_range(0, 99) >= 36;
		end
	end

	// Result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results <= results + 1;
			if (outcome_q.size() == 0) begin
				log_mismatch("result with no item pending", m_tdata[63:0], '0);
			end else begin
				want = outcome_q.pop_front();
				got_rec = m_tdata[CNT_W +: REC_W];
				if (m_tuser !== want.ok)
					log_mismatch("success", m_tuser, want.ok);
				if (m_tdata[CNT_W-1:0] !== want.total)
					log_mismatch("entry_total", m_tdata[CNT_W-1:0], want.total);
				if (got_rec.key !== want.rec.key)
					log_mismatch("out_key", got_rec.key, want.rec.key);
				if (got_rec.name_a !== want.rec.name_a)
					log_mismatch("out_name_a", got_rec.name_a, want.rec.name_a);
				if (got_rec.name_b !== want.rec.name_b)
					log_mismatch("out_name_b", got_rec.name_b, want.rec.name_b);
				if (got_rec.name_c !== want.rec.name_c)
					log_mismatch("out_name_c", got_rec.name_c, want.rec.name_c);
				if (got_rec.name_d !== want.rec.name_d)
					log_mismatch("out_name_d", got_rec.name_d, want.rec.name_d);
				if (got_rec.grade_one !== want.rec.grade_one)
					log_mismatch("out_grade_one", got_rec.grade_one, want.rec.grade_one);
				if (got_rec.grade_two !== want.rec.grade_two)
					log_mismatch("out_grade_two", got_rec.grade_two, want.rec.grade_two);
				if (got_rec.grade_three !== want.rec.grade_three)
					log_mismatch("out_grade_three", got_rec.grade_three,
						want.rec.grade_three);
				if (m_tdata[OUT_W-1:CNT_W+REC_W] !== '0)
					log_mismatch("pad", m_tdata[OUT_W-1:CNT_W+REC_W], '0);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int done_ops;
		int burst;
		int mode;
		int half;
		deque_op_t it;

		// empty list, reserved codes, sorted inserts at the key extremes and on ties
		queue_op(OP_REM_FRONT, 32'd0, FILL_RAND);
		queue_op(OP_REM_BACK, 32'd0, FILL_RAND);
		queue_op(OP_RSVD5, 32'hffff_ffff, FILL_ONES);
		queue_op(OP_RSVD6, 32'd0, FILL_ZERO);
		queue_op(OP_RSVD7, 32'h8000_0000, FILL_ONES);
		queue_op(OP_INS_SORTED, 32'd0, FILL_RAND);
		queue_op(OP_INS_SORTED, 32'h7fff_ffff, FILL_ONES);
		queue_op(OP_INS_SORTED, 32'h8000_0000, FILL_ZERO);
		queue_op(OP_INS_SORTED, 32'd0, FILL_RAND);
		queue_op(OP_INS_SORTED, 32'hffff_ffff, FILL_RAND);
		queue_op(OP_INS_FRONT, 32'd5, FILL_ONES);
		queue_op(OP_INS_BACK, 32'hffff_fffb, FILL_ZERO);
		queue_op(OP_REM_FRONT, 32'd0, FILL_ZERO);
		queue_op(OP_REM_BACK, 32'd0, FILL_ONES);
		queue_op(OP_INS_SORTED, 32'h7fff_ffff, FILL_RAND);
		queue_op(OP_REM_BACK, 32'd0, FILL_RAND);
		queue_op(OP_REM_FRONT, 32'd0, FILL_RAND);
		queue_op(OP_REM_BACK, 32'd0, FILL_RAND);
		queue_op(OP_REM_FRONT, 32'd0, FILL_RAND);
		queue_op(OP_REM_FRONT, 32'd0, FILL_RAND);
		queue_op(OP_REM_BACK, 32'd0, FILL_RAND);
		queue_op(OP_REM_FRONT, 32'd0, FILL_RAND);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();

		// bursts biased toward filling or draining so full and empty come up often
		done_ops = 0;
		for (half = 0; half < 2; half++) begin
			while (done_ops < (half + 1) * RANDOM_OPS / 2) begin
				burst = $urandom_range(8, 40);
				mode = $urandom_range(MODE_FILL, MODE_MIXED);
				repeat (burst) begin
					it = rand_op(mode);
					op_pending_q.push_back(it);
					if (it.op <= OP_INS_SORTED)
						done_ops++;
				end
			end
			wait_drained();
		end

		repeat (4) @(negedge clk);
		if (outcome_q.size() != 0)
			log_mismatch("results never delivered", outcome_q.size(), '0);
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
